### hw/rtl/micts_pkg.sv
// ----------------------------------------------------------------------------
// micts_pkg
// Shared constants, types and saturating helpers for the moving interval
// collision time solver.
// ----------------------------------------------------------------------------
package micts_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;

   localparam int NUM_BITS  = WORD_BITS + 1;
   localparam int QUO_BITS  = NUM_BITS + FRAC_BITS;
   localparam int DIV_LAT   = QUO_BITS + 1;
   localparam int ROOT_BITS = (WORD_BITS + FRAC_BITS) / 2;
   localparam int SQRT_LAT  = ROOT_BITS + 1;
   localparam int PROD_BITS = 2 * WORD_BITS;

   localparam logic signed [63:0] WMAX64 = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] WMIN64 = -WMAX64 - 64'sd1;

   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_TWO  = 2'd2;

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef struct packed {
      word_type val;
      logic     sat;
   } sword_type;

   typedef struct packed {
      logic [NUM_BITS-1:0]  num;
      logic [WORD_BITS-1:0] den;
      logic                 neg;
   } div_in_type;

   function automatic logic signed [63:0] wext(word_type w);
      return 64'(w);
   endfunction

   function automatic logic [63:0] mag64(logic signed [63:0] v);
      logic signed [63:0] n;
      n = -v;
      return v[63] ? n : v;
   endfunction

   function automatic sword_type sat_w(logic signed [63:0] v);
      sword_type r;
      r.sat = 1'b0;
      if (v > WMAX64) begin
         r.val = WMAX64[WORD_BITS-1:0];
         r.sat = 1'b1;
      end else if (v < WMIN64) begin
         r.val = WMIN64[WORD_BITS-1:0];
         r.sat = 1'b1;
      end else begin
         r.val = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/micts_div.sv
// ----------------------------------------------------------------------------
// micts_div
// Pipelined restoring divider: one quotient bit per stage, then a saturating
// signed output register.
// ----------------------------------------------------------------------------
module micts_div (
   input  logic                   clock,
   input  logic                   en,
   input  micts_pkg::div_in_type  din,
   output micts_pkg::sword_type   dout
);
   import micts_pkg::*;

   typedef struct packed {
      logic [WORD_BITS:0]   rem;
      logic [QUO_BITS-1:0]  quo;
      logic [WORD_BITS-1:0] den;
      logic                 neg;
   } div_stage_type;

   div_stage_type stage_ff [QUO_BITS];
   div_stage_type stage_in [QUO_BITS];
   sword_type     out_ff;
   sword_type     out_in;

   always_comb begin
      div_stage_type      src;
      logic [WORD_BITS:0] trial;
      for (int k = 0; k < QUO_BITS; k++) begin
         if (k == 0) begin
            src.rem = '0;
            src.quo = {din.num, {FRAC_BITS{1'b0}}};
            src.den = din.den;
            src.neg = din.neg;
         end else begin
            src = stage_ff[k-1];
         end
         trial = {src.rem[WORD_BITS-1:0], src.quo[QUO_BITS-1]};
         stage_in[k].den = src.den;
         stage_in[k].neg = src.neg;
         if (trial >= {1'b0, src.den}) begin
            stage_in[k].rem = trial - {1'b0, src.den};
            stage_in[k].quo = {src.quo[QUO_BITS-2:0], 1'b1};
         end else begin
            stage_in[k].rem = trial;
            stage_in[k].quo = {src.quo[QUO_BITS-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      logic [QUO_BITS-1:0] q;
      logic [QUO_BITS-1:0] lim;
      logic [QUO_BITS-1:0] qn;
      q   = stage_ff[QUO_BITS-1].quo;
      lim = QUO_BITS'(WMAX64) + QUO_BITS'(stage_ff[QUO_BITS-1].neg);
      out_in.sat = (q > lim);
      if (q > lim) begin
         q = lim;
      end
      qn = -q;
      out_in.val = stage_ff[QUO_BITS-1].neg ? qn[WORD_BITS-1:0] : q[WORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QUO_BITS; k++) begin
            stage_ff[k] <= stage_in[k];
         end
         out_ff <= out_in;
      end
   end

   assign dout = out_ff;

endmodule

### hw/rtl/micts_sqrt.sv
// ----------------------------------------------------------------------------
// micts_sqrt
// Pipelined digit-by-digit square root of a non-negative fixed-point value,
// one root bit per stage, truncated.
// ----------------------------------------------------------------------------
module micts_sqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [micts_pkg::WORD_BITS-2:0] rad,
   output micts_pkg::sword_type          dout
);
   import micts_pkg::*;

   localparam int RAD_BITS = 2 * ROOT_BITS;

   typedef struct packed {
      logic [ROOT_BITS:0]   rem;
      logic [ROOT_BITS-1:0] root;
      logic [RAD_BITS-1:0]  rad;
   } sqrt_stage_type;

   sqrt_stage_type stage_ff [ROOT_BITS];
   sqrt_stage_type stage_in [ROOT_BITS];
   sword_type      out_ff;
   sword_type      out_in;

   always_comb begin
      sqrt_stage_type       src;
      logic [ROOT_BITS+2:0] t;
      logic [ROOT_BITS+2:0] trial;
      for (int k = 0; k < ROOT_BITS; k++) begin
         if (k == 0) begin
            src.rem  = '0;
            src.root = '0;
            src.rad  = RAD_BITS'({rad, {FRAC_BITS{1'b0}}});
         end else begin
            src = stage_ff[k-1];
         end
         t     = {src.rem, src.rad[RAD_BITS-1 -: 2]};
         trial = {1'b0, src.root, 2'b01};
         stage_in[k].rad = {src.rad[RAD_BITS-3:0], 2'b00};
         if (t >= trial) begin
            t = t - trial;
            stage_in[k].rem  = t[ROOT_BITS:0];
            stage_in[k].root = {src.root[ROOT_BITS-2:0], 1'b1};
         end else begin
            stage_in[k].rem  = t[ROOT_BITS:0];
            stage_in[k].root = {src.root[ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      out_in = sat_w(signed'(64'(stage_ff[ROOT_BITS-1].root)));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ROOT_BITS; k++) begin
            stage_ff[k] <= stage_in[k];
         end
         out_ff <= out_in;
      end
   end

   assign dout = out_ff;

endmodule

### hw/rtl/moving_interval_collision_times.sv
// ----------------------------------------------------------------------------
// moving_interval_collision_times
// Solves the two meeting times of two accelerating 1-D intervals and returns
// up to two overlap windows.
// ----------------------------------------------------------------------------
// The bit-serial divider and square root pipelines make up most of the
// pipeline depth. Accepts one request per cycle while rsp_ready keeps the
// pipeline moving; while a result waits, an input skid register takes one
// more request and req_ready then drops. Reset clears all valid bits,
// including the skid register's valid bit.
module moving_interval_collision_times (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_first_start,
   input  logic signed [31:0] req_first_velocity,
   input  logic signed [31:0] req_first_accel,
   input  logic [30:0]        req_first_width,
   input  logic signed [31:0] req_second_start,
   input  logic signed [31:0] req_second_velocity,
   input  logic signed [31:0] req_second_accel,
   input  logic [30:0]        req_second_width,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_window_count,
   output logic signed [31:0] rsp_first_enter,
   output logic signed [31:0] rsp_first_leave,
   output logic signed [31:0] rsp_second_enter,
   output logic signed [31:0] rsp_second_leave,
   output logic               rsp_saturated
);
   import micts_pkg::*;

   localparam logic signed [63:0] T_MAX = 64'sd2147483647;
   localparam logic signed [63:0] T_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] s1;
      logic signed [31:0] v1;
      logic signed [31:0] a1;
      logic [30:0]        w1;
      logic signed [31:0] s2;
      logic signed [31:0] v2;
      logic signed [31:0] a2;
      logic [30:0]        w2;
   } req_type;

   typedef struct packed {
      logic     valid;
      logic     sat;
      word_type dx1;
      word_type dx2;
      word_type dv;
      word_type da;
   } p1_type;

   typedef struct packed {
      logic valid;
      logic quad;
      logic dvz;
      logic dx1z;
      logic dx2z;
      logic sat;
   } ctx1_type;

   typedef struct packed {
      ctx1_type             c;
      logic [PROD_BITS-1:0] prod;
      word_type             h;
      word_type             q1;
      word_type             q2;
   } p2_type;

   typedef struct packed {
      ctx1_type c;
      word_type h;
      word_type disc1;
      word_type disc2;
      word_type lin1;
      word_type lin2;
   } p3_type;

   typedef struct packed {
      ctx1_type c;
      word_type h;
      word_type lin1;
      word_type lin2;
      logic     d1neg;
      logic     d2neg;
   } ctx2_type;

   typedef struct packed {
      logic [1:0] cnt;
      word_type   ra;
      word_type   rb;
      logic       sat;
   } root_type;

   typedef struct packed {
      logic     valid;
      logic     sat;
      root_type l;
      root_type r;
   } p4_type;

   typedef struct packed {
      logic [1:0]         count;
      logic signed [31:0] t0;
      logic signed [31:0] t1;
      logic signed [31:0] t2;
      logic signed [31:0] t3;
      logic               sat;
   } rsp_type;

   function automatic div_in_type make_div(logic signed [63:0] n, logic signed [63:0] d);
      div_in_type r;
      logic [63:0] nm;
      logic [63:0] dm;
      nm    = mag64(n);
      dm    = mag64(d);
      r.num = nm[NUM_BITS-1:0];
      r.den = dm[WORD_BITS-1:0];
      r.neg = n[63] ^ d[63];
      return r;
   endfunction

   function automatic root_type roots(logic quad, logic dvz, logic dxz, logic dneg,
                                      word_type h, sword_type s, word_type lin);
      root_type  r;
      sword_type lo;
      sword_type hi;
      lo    = sat_w(-wext(h) - wext(s.val));
      hi    = sat_w(-wext(h) + wext(s.val));
      r.cnt = CNT_NONE;
      r.ra  = '0;
      r.rb  = '0;
      r.sat = 1'b0;
      if (quad) begin
         if (!dneg) begin
            r.cnt = CNT_TWO;
            r.ra  = lo.val;
            r.rb  = hi.val;
            r.sat = lo.sat | hi.sat | s.sat;
         end
      end else if (dvz) begin
         r.cnt = dxz ? CNT_ONE : CNT_NONE;
      end else begin
         r.cnt = CNT_ONE;
         r.ra  = lin;
      end
      return r;
   endfunction

   function automatic logic [32:0] clamp32(word_type w);
      logic signed [63:0] v;
      v = wext(w);
      if (v > T_MAX) begin
         return {T_MAX[31:0], 1'b1};
      end else if (v < T_MIN) begin
         return {T_MIN[31:0], 1'b1};
      end
      return {v[31:0], 1'b0};
   endfunction

   logic       en;
   req_type    req_in;
   req_type    skid_ff;
   logic       skid_valid_ff;
   req_type    in_ff;
   logic       in_valid_ff;
   p1_type     p1_ff;
   p1_type     p1_in;
   ctx1_type   c1_ff [DIV_LAT];
   ctx1_type   c1_in;
   div_in_type div_h;
   div_in_type div_1;
   div_in_type div_2;
   sword_type  h_out;
   sword_type  q1_out;
   sword_type  q2_out;
   p2_type     p2_ff;
   p2_type     p2_in;
   p3_type     p3_ff;
   p3_type     p3_in;
   ctx2_type   c2_ff [SQRT_LAT];
   ctx2_type   c2_in;
   logic [WORD_BITS-2:0] rad1;
   logic [WORD_BITS-2:0] rad2;
   sword_type  s1_out;
   sword_type  s2_out;
   p4_type     p4_ff;
   p4_type     p4_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = !skid_valid_ff;

   assign req_in = '{s1: req_first_start, v1: req_first_velocity, a1: req_first_accel,
                     w1: req_first_width, s2: req_second_start, v2: req_second_velocity,
                     a2: req_second_accel, w2: req_second_width};

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
         in_valid_ff   <= 1'b0;
      end else if (en) begin
         in_valid_ff   <= skid_valid_ff | req_valid;
         in_ff         <= skid_valid_ff ? skid_ff : req_in;
         skid_valid_ff <= 1'b0;
      end else if (req_valid && !skid_valid_ff) begin
         skid_ff       <= req_in;
         skid_valid_ff <= 1'b1;
      end
   end

   always_comb begin
      sword_type s1;
      sword_type v1;
      sword_type a1;
      sword_type w1;
      sword_type s2;
      sword_type v2;
      sword_type a2;
      sword_type w2;
      sword_type e1;
      sword_type e2;
      sword_type dx1;
      sword_type dx2;
      sword_type dv;
      sword_type da;
      s1  = sat_w(64'(in_ff.s1));
      v1  = sat_w(64'(in_ff.v1));
      a1  = sat_w(64'(in_ff.a1));
      w1  = sat_w(signed'({33'd0, in_ff.w1}));
      s2  = sat_w(64'(in_ff.s2));
      v2  = sat_w(64'(in_ff.v2));
      a2  = sat_w(64'(in_ff.a2));
      w2  = sat_w(signed'({33'd0, in_ff.w2}));
      e1  = sat_w(wext(s1.val) + wext(w1.val));
      e2  = sat_w(wext(s2.val) + wext(w2.val));
      dx1 = sat_w(wext(e1.val) - wext(s2.val));
      dx2 = sat_w(wext(s1.val) - wext(e2.val));
      dv  = sat_w(wext(v1.val) - wext(v2.val));
      da  = sat_w(wext(a1.val) - wext(a2.val));
      p1_in.valid = in_valid_ff;
      p1_in.sat   = s1.sat | v1.sat | a1.sat | w1.sat | s2.sat | v2.sat | a2.sat | w2.sat
                  | e1.sat | e2.sat | dx1.sat | dx2.sat | dv.sat | da.sat;
      p1_in.dx1   = dx1.val;
      p1_in.dx2   = dx2.val;
      p1_in.dv    = dv.val;
      p1_in.da    = da.val;
   end

   always_comb begin
      logic quad;
      quad        = (p1_ff.da != '0);
      c1_in.valid = p1_ff.valid;
      c1_in.quad  = quad;
      c1_in.dvz   = (p1_ff.dv == '0);
      c1_in.dx1z  = (p1_ff.dx1 == '0);
      c1_in.dx2z  = (p1_ff.dx2 == '0);
      c1_in.sat   = p1_ff.sat;
      div_h = make_div(wext(p1_ff.dv), wext(p1_ff.da));
      div_1 = make_div(quad ? (wext(p1_ff.dx1) <<< 1) : wext(p1_ff.dx1),
                       quad ? wext(p1_ff.da) : wext(p1_ff.dv));
      div_2 = make_div(quad ? (wext(p1_ff.dx2) <<< 1) : wext(p1_ff.dx2),
                       quad ? wext(p1_ff.da) : wext(p1_ff.dv));
   end

   micts_div u_div_h (.clock(clock), .en(en), .din(div_h), .dout(h_out));
   micts_div u_div_1 (.clock(clock), .en(en), .din(div_1), .dout(q1_out));
   micts_div u_div_2 (.clock(clock), .en(en), .din(div_2), .dout(q2_out));

   always_comb begin
      ctx1_type c;
      logic [63:0] hm;
      logic [WORD_BITS-1:0] hw;
      c  = c1_ff[DIV_LAT-1];
      hm = mag64(wext(h_out.val));
      hw = hm[WORD_BITS-1:0];
      p2_in.c = c;
      if (c.quad) begin
         p2_in.c.sat = c.sat | h_out.sat | q1_out.sat | q2_out.sat;
      end else begin
         p2_in.c.sat = c.sat | (!c.dvz & (q1_out.sat | q2_out.sat));
      end
      p2_in.prod = PROD_BITS'(hw) * PROD_BITS'(hw);
      p2_in.h    = h_out.val;
      p2_in.q1   = q1_out.val;
      p2_in.q2   = q2_out.val;
   end

   always_comb begin
      logic [PROD_BITS-1:0] m;
      logic                 hsat;
      word_type             hh;
      sword_type            d1;
      sword_type            d2;
      sword_type            l1;
      sword_type            l2;
      m    = p2_ff.prod >> FRAC_BITS;
      hsat = (m > PROD_BITS'(WMAX64));
      hh   = hsat ? WMAX64[WORD_BITS-1:0] : m[WORD_BITS-1:0];
      d1   = sat_w(wext(hh) - wext(p2_ff.q1));
      d2   = sat_w(wext(hh) - wext(p2_ff.q2));
      l1   = sat_w(-wext(p2_ff.q1));
      l2   = sat_w(-wext(p2_ff.q2));
      p3_in.c = p2_ff.c;
      if (p2_ff.c.quad) begin
         p3_in.c.sat = p2_ff.c.sat | hsat | d1.sat | d2.sat;
      end else begin
         p3_in.c.sat = p2_ff.c.sat | (!p2_ff.c.dvz & (l1.sat | l2.sat));
      end
      p3_in.h     = p2_ff.h;
      p3_in.disc1 = d1.val;
      p3_in.disc2 = d2.val;
      p3_in.lin1  = l1.val;
      p3_in.lin2  = l2.val;
   end

   always_comb begin
      rad1 = (p3_ff.disc1 > 0) ? p3_ff.disc1[WORD_BITS-2:0] : '0;
      rad2 = (p3_ff.disc2 > 0) ? p3_ff.disc2[WORD_BITS-2:0] : '0;
      c2_in.c     = p3_ff.c;
      c2_in.h     = p3_ff.h;
      c2_in.lin1  = p3_ff.lin1;
      c2_in.lin2  = p3_ff.lin2;
      c2_in.d1neg = p3_ff.disc1[WORD_BITS-1];
      c2_in.d2neg = p3_ff.disc2[WORD_BITS-1];
   end

   micts_sqrt u_sqrt_1 (.clock(clock), .en(en), .rad(rad1), .dout(s1_out));
   micts_sqrt u_sqrt_2 (.clock(clock), .en(en), .rad(rad2), .dout(s2_out));

   always_comb begin
      ctx2_type c;
      c = c2_ff[SQRT_LAT-1];
      p4_in.valid = c.c.valid;
      p4_in.l = roots(c.c.quad, c.c.dvz, c.c.dx1z, c.d1neg, c.h, s1_out, c.lin1);
      p4_in.r = roots(c.c.quad, c.c.dvz, c.c.dx2z, c.d2neg, c.h, s2_out, c.lin2);
      p4_in.sat = c.c.sat | p4_in.l.sat | p4_in.r.sat;
   end

   always_comb begin
      word_type    t0;
      word_type    t1;
      word_type    t2;
      word_type    t3;
      logic [32:0] k0;
      logic [32:0] k1;
      logic [32:0] k2;
      logic [32:0] k3;
      root_type    l;
      root_type    r;
      l  = p4_ff.l;
      r  = p4_ff.r;
      t0 = '0;
      t1 = '0;
      t2 = '0;
      t3 = '0;
      rsp_in.count = CNT_NONE;
      if (l.cnt == CNT_ONE && r.cnt == CNT_ONE) begin
         rsp_in.count = CNT_ONE;
         t0 = (l.ra < r.ra) ? l.ra : r.ra;
         t1 = (l.ra > r.ra) ? l.ra : r.ra;
      end else if (l.cnt == CNT_TWO && r.cnt == CNT_TWO) begin
         rsp_in.count = CNT_TWO;
         t0 = (l.ra < r.ra) ? l.ra : r.ra;
         t1 = (l.ra > r.ra) ? l.ra : r.ra;
         t2 = (l.rb < r.rb) ? l.rb : r.rb;
         t3 = (l.rb > r.rb) ? l.rb : r.rb;
      end else if (l.cnt == CNT_TWO && r.cnt == CNT_NONE) begin
         rsp_in.count = CNT_ONE;
         t0 = l.ra;
         t1 = l.rb;
      end else if (l.cnt == CNT_NONE && r.cnt == CNT_TWO) begin
         rsp_in.count = CNT_ONE;
         t0 = r.ra;
         t1 = r.rb;
      end
      k0 = clamp32(t0);
      k1 = clamp32(t1);
      k2 = clamp32(t2);
      k3 = clamp32(t3);
      rsp_in.t0  = k0[32:1];
      rsp_in.t1  = k1[32:1];
      rsp_in.t2  = k2[32:1];
      rsp_in.t3  = k3[32:1];
      rsp_in.sat = p4_ff.sat | k0[0] | k1[0] | k2[0] | k3[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff.valid  <= 1'b0;
         p2_ff.c.valid <= 1'b0;
         p3_ff.c.valid <= 1'b0;
         p4_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < DIV_LAT; k++) begin
            c1_ff[k].valid <= 1'b0;
         end
         for (int k = 0; k < SQRT_LAT; k++) begin
            c2_ff[k].c.valid <= 1'b0;
         end
      end else if (en) begin
         p1_ff <= p1_in;
         c1_ff[0] <= c1_in;
         for (int k = 1; k < DIV_LAT; k++) begin
            c1_ff[k] <= c1_ff[k-1];
         end
         p2_ff <= p2_in;
         p3_ff <= p3_in;
         c2_ff[0] <= c2_in;
         for (int k = 1; k < SQRT_LAT; k++) begin
            c2_ff[k] <= c2_ff[k-1];
         end
         p4_ff        <= p4_in;
         rsp_ff       <= rsp_in;
         rsp_valid_ff <= p4_ff.valid;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_count = rsp_ff.count;
   assign rsp_first_enter  = rsp_ff.t0;
   assign rsp_first_leave  = rsp_ff.t1;
   assign rsp_second_enter = rsp_ff.t2;
   assign rsp_second_leave = rsp_ff.t3;
   assign rsp_saturated    = rsp_ff.sat;

endmodule

### bench/micts_checker.sv
// ----------------------------------------------------------------------------
// micts_checker
// Watches the request and response channels of the collision time solver,
// predicts each response from the accepted request and compares field by
// field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module micts_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_first_start,
   input  logic signed [31:0] req_first_velocity,
   input  logic signed [31:0] req_first_accel,
   input  logic [30:0]        req_first_width,
   input  logic signed [31:0] req_second_start,
   input  logic signed [31:0] req_second_velocity,
   input  logic signed [31:0] req_second_accel,
   input  logic [30:0]        req_second_width,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_window_count,
   input  logic signed [31:0] rsp_first_enter,
   input  logic signed [31:0] rsp_first_leave,
   input  logic signed [31:0] rsp_second_enter,
   input  logic signed [31:0] rsp_second_leave,
   input  logic               rsp_saturated,
   output int                 error_count,
   output int                 outstanding
);
   import micts_pkg::*;

   localparam int FB = FRAC_BITS;
   localparam longint WTOP = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
   localparam longint WBOT = -WTOP - 64'sd1;

   typedef struct {
      logic [1:0]         count;
      logic signed [31:0] times [4];
      logic               sat;
   } window_set_type;

   window_set_type pending_windows [$];
   bit             clamp_hit;

   function automatic longint wsat(longint v);
      if (v > WTOP) begin
         clamp_hit = 1'b1;
         return WTOP;
      end
      if (v < WBOT) begin
         clamp_hit = 1'b1;
         return WBOT;
      end
      return v;
   endfunction

   function automatic logic [63:0] magn(longint v);
      return v < 0 ? 64'd0 - 64'(v) : 64'(v);
   endfunction

   function automatic longint signed_from_mag(logic [63:0] m, bit neg);
      logic [63:0] lim;
      lim = 64'(WTOP) + (neg ? 64'd1 : 64'd0);
      if (m > lim) begin
         clamp_hit = 1'b1;
         m = lim;
      end
      return neg ? longint'(64'd0 - m) : longint'(m);
   endfunction

   function automatic longint qmul(longint a, longint b);
      logic [127:0] p;
      logic [63:0]  m;
      p = {64'd0, magn(a)} * {64'd0, magn(b)};
      if (p[127:64+FB] != 0) m = '1;
      else m = p[64+FB-1:FB];
      return signed_from_mag(m, (a < 0) != (b < 0));
   endfunction

   function automatic longint qdiv(longint n, longint d);
      bit          neg;
      logic [63:0] un, ud, q, r, lim;
      neg = (n < 0) != (d < 0);
      un  = magn(n);
      ud  = magn(d);
      lim = 64'(WTOP) + 64'd1;
      q   = un / ud;
      r   = un % ud;
      for (int i = 0; i < FB && q <= lim; i++) begin
         q = q << 1;
         r = r << 1;
         if (r >= ud) begin
            q = q | 64'd1;
            r = r - ud;
         end
      end
      if (q > lim) q = '1;
      return signed_from_mag(q, neg);
   endfunction

   function automatic longint qsqrt(longint v);
      logic [127:0] target;
      logic [63:0]  r, c;
      target = {64'd0, 64'(v)} << FB;
      r = 0;
      for (int b = 40; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= target) r = c;
      end
      return signed_from_mag(r, 1'b0);
   endfunction

   function automatic int meeting_roots(longint xa, longint va, longint aa, longint xb,
                                        longint vb, longint ab, output longint ra,
                                        output longint rb);
      longint dx, dv, da, h, q, disc, s;
      dx = wsat(xa - xb);
      dv = wsat(va - vb);
      da = wsat(aa - ab);
      ra = 0;
      rb = 0;
      if (da != 0) begin
         h    = qdiv(dv, da);
         q    = qdiv(2 * dx, da);
         disc = wsat(qmul(h, h) - q);
         if (disc < 0) return 0;
         s  = (disc == 0) ? 0 : qsqrt(disc);
         ra = wsat(-h - s);
         rb = wsat(-h + s);
         return 2;
      end
      if (dv == 0) return dx == 0 ? 1 : 0;
      ra = wsat(-qdiv(dx, dv));
      return 1;
   endfunction

   function automatic logic signed [31:0] out_time(longint t);
      if (t > 64'sh7fffffff) begin
         clamp_hit = 1'b1;
         t = 64'sh7fffffff;
      end else if (t < -64'sh80000000) begin
         clamp_hit = 1'b1;
         t = -64'sh80000000;
      end
      return t[31:0];
   endfunction

   function automatic window_set_type predict_windows();
      window_set_type ws;
      longint s1, v1, a1, w1, s2, v2, a2, w2, l1, l2, r1, r2;
      longint t [4];
      int     n1, n2;
      clamp_hit = 1'b0;
      t  = '{0, 0, 0, 0};
      s1 = wsat(longint'(req_first_start));
      v1 = wsat(longint'(req_first_velocity));
      a1 = wsat(longint'(req_first_accel));
      w1 = wsat(longint'({1'b0, req_first_width}));
      s2 = wsat(longint'(req_second_start));
      v2 = wsat(longint'(req_second_velocity));
      a2 = wsat(longint'(req_second_accel));
      w2 = wsat(longint'({1'b0, req_second_width}));
      n1 = meeting_roots(wsat(s1 + w1), v1, a1, s2, v2, a2, l1, l2);
      n2 = meeting_roots(s1, v1, a1, wsat(s2 + w2), v2, a2, r1, r2);
      ws.count = CNT_NONE;
      if (n1 == 1 && n2 == 1) begin
         ws.count = CNT_ONE;
         t[0] = l1 < r1 ? l1 : r1;
         t[1] = l1 > r1 ? l1 : r1;
      end else if (n1 == 2 && n2 == 2) begin
         ws.count = CNT_TWO;
         t[0] = l1 < r1 ? l1 : r1;
         t[1] = l1 > r1 ? l1 : r1;
         t[2] = l2 < r2 ? l2 : r2;
         t[3] = l2 > r2 ? l2 : r2;
      end else if (n1 == 2 && n2 == 0) begin
         ws.count = CNT_ONE;
         t[0] = l1;
         t[1] = l2;
      end else if (n1 == 0 && n2 == 2) begin
         ws.count = CNT_ONE;
         t[0] = r1;
         t[1] = r2;
      end
      for (int i = 0; i < 4; i++) ws.times[i] = out_time(t[i]);
      ws.sat = clamp_hit;
      return ws;
   endfunction

   task automatic report(string field, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      window_set_type w;
      if (reset) begin
         pending_windows.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_windows.size() == 0) begin
               $display("unexpected response at %0t", $time);
               error_count++;
            end else begin
               w = pending_windows.pop_front();
               if (rsp_window_count != w.count)
                  report("window_count", rsp_window_count, w.count);
               if (rsp_first_enter != w.times[0])
                  report("first_enter", rsp_first_enter, w.times[0]);
               if (rsp_first_leave != w.times[1])
                  report("first_leave", rsp_first_leave, w.times[1]);
               if (rsp_second_enter != w.times[2])
                  report("second_enter", rsp_second_enter, w.times[2]);
               if (rsp_second_leave != w.times[3])
                  report("second_leave", rsp_second_leave, w.times[3]);
               if (rsp_saturated != w.sat)
                  report("saturated", rsp_saturated, w.sat);
            end
         end
         if (req_valid && req_ready) pending_windows.push_back(predict_windows());
      end
      outstanding = pending_windows.size();
   end

endmodule

### bench/tb_moving_interval_collision_times.sv
// ----------------------------------------------------------------------------
// tb_moving_interval_collision_times
// Drives directed and random interval pairs into the collision time solver
// under varying sender and receiver idling, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_moving_interval_collision_times;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_first_start = '0;
   logic signed [31:0] req_first_velocity = '0;
   logic signed [31:0] req_first_accel = '0;
   logic [30:0]        req_first_width = '0;
   logic signed [31:0] req_second_start = '0;
   logic signed [31:0] req_second_velocity = '0;
   logic signed [31:0] req_second_accel = '0;
   logic [30:0]        req_second_width = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_window_count;
   logic signed [31:0] rsp_first_enter;
   logic signed [31:0] rsp_first_leave;
   logic signed [31:0] rsp_second_enter;
   logic signed [31:0] rsp_second_leave;
   logic               rsp_saturated;
   logic               req_taken = 1'b0;
   int                 error_count;
   int                 outstanding;
   int                 send_idle_pct = 20;
   int                 recv_stall_pct = 78;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   moving_interval_collision_times u_top (.*);

   micts_checker u_checker (.*);

   always @(posedge clock) req_taken <= req_valid && req_ready;

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   task automatic send_pair(logic [31:0] s1, logic [31:0] v1, logic [31:0] a1, logic [30:0] w1,
                            logic [31:0] s2, logic [31:0] v2, logic [31:0] a2, logic [30:0] w2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid           = 1'b1;
      req_first_start     = s1;
      req_first_velocity  = v1;
      req_first_accel     = a1;
      req_first_width     = w1;
      req_second_start    = s2;
      req_second_velocity = v2;
      req_second_accel    = a2;
      req_second_width    = w2;
      do @(negedge clock); while (!req_taken);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(6))
         0: return 32'h0;
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         3: return $urandom;
         4: return 32'($signed($urandom_range(2 << 20)) - (1 << 20));
         default: return 32'($signed($urandom_range(16 << 16)) - (8 << 16));
      endcase
   endfunction

   function automatic logic [30:0] rand_width();
      case ($urandom_range(4))
         0: return 31'h0;
         1: return 31'h7fffffff;
         2: return 31'($urandom);
         default: return 31'($urandom_range(8 << 16));
      endcase
   endfunction

   task automatic send_random_pair();
      logic [31:0] s1, v1, a1, s2, v2, a2;
      s1 = rand_word();
      v1 = rand_word();
      a1 = rand_word();
      s2 = rand_word();
      v2 = rand_word();
      a2 = ($urandom_range(2) == 0) ? a1 : rand_word();
      if ($urandom_range(4) == 0) v2 = v1;
      if ($urandom_range(9) == 0) s2 = s1;
      send_pair(s1, v1, a1, rand_width(), s2, v2, a2, rand_width());
   endtask

   task automatic drain_responses();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (2) @(negedge clock);
      reset = 1'b0;
      // Directed part: zeros, extremes, linear cases, double root, no root.
      send_pair(0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff);
      send_pair(32'h80000000, 32'h80000000, 32'h80000000, 0,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
      send_pair(32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff,
                0, 0, 0, 31'h7fffffff);
      send_pair(0, 32'h10000, 0, 31'h10000, 32'h50000, 0, 0, 31'h10000);
      send_pair(0, 0, 0, 31'h10000, 32'h50000, 0, 0, 31'h10000);
      send_pair(0, 0, 0, 0, 0, 0, 0, 31'h10000);
      send_pair(0, 0, 32'h20000, 31'h10000, 32'h50000, 0, 0, 31'h10000);
      send_pair(0, 0, 32'h20000, 31'h10000, 32'h10000, 0, 0, 0);
      send_pair(0, 0, 32'h20000, 0, 32'h50000, 0, 0, 0);
      send_pair(32'h50000, 0, 32'h20000, 0, 0, 0, 0, 0);
      send_pair(0, 32'h10000, 32'h10000, 31'h8000, 32'h30000, 0, 0, 31'h8000);
      send_pair(0, 32'h20000, 32'h10000, 31'h10000, 32'h20000, 32'h20000, 32'h10000, 0);
      send_pair(0, 32'h7fffffff, 32'h1, 31'h10000, 32'h100000, 0, 0, 31'h10000);
      send_pair(32'h80000000, 32'h1, 32'h7fffffff, 31'h7fffffff,
                32'h7fffffff, 32'hffffffff, 32'h80000000, 31'h7fffffff);
      send_pair(0, 32'hfffe0000, 0, 31'h20000, 32'hfff00000, 32'h10000, 0, 31'h20000);
      send_pair(0, 0, 0, 31'h7fffffff, 32'h80000000, 0, 0, 0);
      send_pair(0, 0, 32'h1, 0, 0, 32'h7fffffff, 0, 0);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 20 : (phase == 1) ? 78 : 0;
         recv_stall_pct = (phase == 0) ? 78 : (phase == 1) ? 20 : 0;
         for (int n = 0; n < 200; n++) begin
            send_random_pair();
            if (n == 100) drain_responses();
         end
      end
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
